/* hw/rtl/phf_pkg.sv */
package phf_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 1024;

   localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
   localparam logic [31:0] CRC_ONES = 32'hffff_ffff;
   localparam logic [15:0] HDR_BYTES = 16'd32;

   localparam int unsigned WORD_IDX_W = 3;
   localparam int unsigned CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STREAM_IDENT   = 2'd0,
      CSR_MAGIC_WORD     = 2'd1,
      CSR_FORMAT_VERSION = 2'd2
   } csr_index_type;

   localparam logic [WORD_IDX_W-1:0] WORD_MAGIC    = 3'd0;
   localparam logic [WORD_IDX_W-1:0] WORD_VERSION  = 3'd1;
   localparam logic [WORD_IDX_W-1:0] WORD_STREAM   = 3'd2;
   localparam logic [WORD_IDX_W-1:0] WORD_SEQUENCE = 3'd3;
   localparam logic [WORD_IDX_W-1:0] WORD_KIND     = 3'd4;
   localparam logic [WORD_IDX_W-1:0] WORD_LENGTH   = 3'd5;
   localparam logic [WORD_IDX_W-1:0] WORD_CRC      = 3'd6;
   localparam logic [WORD_IDX_W-1:0] WORD_LAST     = 3'd7;

   typedef struct packed {
      logic        dropped;
      logic [31:0] magic_word;
      logic [15:0] format_version;
      logic [31:0] stream_ident;
      logic [31:0] sequence_num;
      logic [15:0] pkt_kind;
      logic [15:0] pkt_flags;
      logic [31:0] length;
      logic [31:0] crc;
   } hdr_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] v;
      v = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

endpackage

/* hw/rtl/phf_core.sv */
module phf_core #(
   parameter int unsigned MAX_PAYLOAD = phf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [phf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                        csr_data,
   input  logic                               req_fire,
   input  logic                               req_mode,
   input  logic [7:0]                         req_data_byte,
   input  logic [15:0]                        req_pkt_kind,
   input  logic [15:0]                        req_pkt_flags,
   output phf_pkg::hdr_type                   hdr
);

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 2);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

   logic [31:0]      stream_ident_ff, stream_ident_in;
   logic [31:0]      magic_word_ff, magic_word_in;
   logic [15:0]      format_version_ff, format_version_in;
   logic [31:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      sequence_ff, sequence_in;
   logic             oversize;

   assign oversize = count_ff > CNT_MAX;

   always_comb begin
      hdr.dropped        = oversize;
      hdr.magic_word     = magic_word_ff;
      hdr.format_version = format_version_ff;
      hdr.stream_ident   = stream_ident_ff;
      hdr.sequence_num   = sequence_ff;
      hdr.pkt_kind       = req_pkt_kind;
      hdr.pkt_flags      = req_pkt_flags;
      hdr.length         = 32'(count_ff);
      hdr.crc            = ~crc_ff;
   end

   always_comb begin
      stream_ident_in   = stream_ident_ff;
      magic_word_in     = magic_word_ff;
      format_version_in = format_version_ff;
      crc_in            = crc_ff;
      count_in          = count_ff;
      sequence_in       = sequence_ff;
      if (req_fire) begin
         if (!req_mode) begin
            crc_in = phf_pkg::crc_byte(crc_ff, req_data_byte);
            if (!oversize) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            crc_in   = phf_pkg::CRC_ONES;
            count_in = '0;
            if (!oversize) begin
               sequence_in = sequence_ff + 32'd1;
            end
         end
      end
      if (csr_write) begin
         unique case (csr_index)
            phf_pkg::CSR_STREAM_IDENT: begin
               stream_ident_in = (csr_data == 32'd0) ? 32'd1 : csr_data;
               sequence_in     = 32'd0;
            end
            phf_pkg::CSR_MAGIC_WORD: begin
               magic_word_in = csr_data;
            end
            phf_pkg::CSR_FORMAT_VERSION: begin
               format_version_in = csr_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_ident_ff   <= 32'd1;
         magic_word_ff     <= 32'd0;
         format_version_ff <= 16'd1;
         crc_ff            <= phf_pkg::CRC_ONES;
         count_ff          <= '0;
         sequence_ff       <= 32'd0;
      end else begin
         stream_ident_ff   <= stream_ident_in;
         magic_word_ff     <= magic_word_in;
         format_version_ff <= format_version_in;
         crc_ff            <= crc_in;
         count_ff          <= count_in;
         sequence_ff       <= sequence_in;
      end
   end

endmodule

/* hw/rtl/phf_emit.sv */
module phf_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  phf_pkg::hdr_type                  hdr,
   output logic                              done,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_header_word,
   output logic [phf_pkg::WORD_IDX_W-1:0]    rsp_word_index,
   output logic                              rsp_dropped,
   output logic                              rsp_last_word
);

   logic                           busy_ff, busy_in;
   logic [phf_pkg::WORD_IDX_W-1:0] idx_ff, idx_in;
   phf_pkg::hdr_type               hdr_ff;
   logic [31:0]                    word;
   logic                           last;

   always_comb begin
      case (idx_ff)
         phf_pkg::WORD_MAGIC:    word = hdr_ff.magic_word;
         phf_pkg::WORD_VERSION:  word = {phf_pkg::HDR_BYTES, hdr_ff.format_version};
         phf_pkg::WORD_STREAM:   word = hdr_ff.stream_ident;
         phf_pkg::WORD_SEQUENCE: word = hdr_ff.sequence_num;
         phf_pkg::WORD_KIND:     word = {hdr_ff.pkt_flags, hdr_ff.pkt_kind};
         phf_pkg::WORD_LENGTH:   word = hdr_ff.length;
         phf_pkg::WORD_CRC:      word = hdr_ff.crc;
         default:                word = 32'd0;
      endcase
   end

   assign last            = hdr_ff.dropped || (idx_ff == phf_pkg::WORD_LAST);
   assign rsp_valid       = busy_ff;
   assign rsp_header_word = hdr_ff.dropped ? 32'd0 : word;
   assign rsp_word_index  = idx_ff;
   assign rsp_dropped     = hdr_ff.dropped;
   assign rsp_last_word   = last;
   assign done            = busy_ff && !rsp_stall && last;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (busy_ff && !rsp_stall) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + phf_pkg::WORD_IDX_W'(1);
         end
      end
      if (load) begin
         busy_in = 1'b1;
         idx_in  = phf_pkg::WORD_MAGIC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= phf_pkg::WORD_MAGIC;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hdr_ff <= hdr;
      end
   end

endmodule

/* hw/rtl/packet_header_framer_crc32_unit.sv */
// packet header framer with running crc-32
// req channel: one item per transfer; req_mode 0 carries a payload byte,
// req_mode 1 closes the packet and carries kind and flags
// payload bytes are taken every cycle and produce no response; crc and
// byte count update in the cycle of the transfer
// a close transfer yields eight rsp transfers, header words 0 to 7 in order,
// or a single transfer with rsp_dropped set when the payload was oversized
// first header word is valid the cycle after the close transfer
// throughput: one payload byte per cycle; one header word per cycle while
// rsp_stall is low; the response side is busy until the last word is sent
// payload bytes of the next packet keep flowing while a header is sent;
// a second close is stalled until the last word of the current header
// transfers (it is taken in that same cycle)
// when rsp_stall is high the current word holds and the word counter waits
// csr channel is always ready; write only while no header is pending
// reset: synchronous, clears crc, count, sequence and registers to defaults,
// response side empty
module packet_header_framer_crc32_unit #(
   parameter int unsigned MAX_PAYLOAD = phf_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [7:0]                        req_data_byte,
   input  logic [15:0]                       req_pkt_kind,
   input  logic [15:0]                       req_pkt_flags,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_header_word,
   output logic [phf_pkg::WORD_IDX_W-1:0]    rsp_word_index,
   output logic                              rsp_dropped,
   output logic                              rsp_last_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [phf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_data
);

   phf_pkg::hdr_type hdr;
   logic             req_fire;
   logic             close_load;
   logic             emit_done;

   assign csr_ready  = 1'b1;
   assign req_stall  = req_mode && rsp_valid && !emit_done;
   assign req_fire   = req_valid && !req_stall;
   assign close_load = req_fire && req_mode;

   phf_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_fire      (req_fire),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .req_pkt_kind  (req_pkt_kind),
      .req_pkt_flags (req_pkt_flags),
      .hdr           (hdr)
   );

   phf_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (close_load),
      .hdr             (hdr),
      .done            (emit_done),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_header_word (rsp_header_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_dropped     (rsp_dropped),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

/* hw/rtl/phf_checker.sv */
module phf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [31:0]                       rsp_header_word,
   input logic [phf_pkg::WORD_IDX_W-1:0]    rsp_word_index,
   input logic                              rsp_dropped,
   input logic                              rsp_last_word
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_drop_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |->
         (rsp_last_word && rsp_word_index == phf_pkg::WORD_MAGIC &&
          rsp_header_word == 32'd0))
      else $error("malformed dropped response");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("header words out of order");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_word && !rsp_dropped) |->
         (rsp_word_index == phf_pkg::WORD_LAST && rsp_header_word == 32'd0))
      else $error("bad final header word");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_header_word)))
      else $error("stalled response changed");

endmodule

bind packet_header_framer_crc32_unit phf_checker u_phf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_header_word (rsp_header_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_dropped     (rsp_dropped),
   .rsp_last_word   (rsp_last_word)
);

/* tb/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_ITEMS = 310;
   localparam int unsigned LONG_HOLD = 300;
   localparam logic [phf_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic                              req_mode;
   logic [7:0]                        req_data_byte;
   logic [15:0]                       req_pkt_kind;
   logic [15:0]                       req_pkt_flags;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [31:0]                       rsp_header_word;
   logic [phf_pkg::WORD_IDX_W-1:0]    rsp_word_index;
   logic                              rsp_dropped;
   logic                              rsp_last_word;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [phf_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [31:0]                       csr_data;

   bit          calm = 1'b0;
   bit          hold_req = 1'b0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;

   packet_header_framer_crc32_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_data_byte   (req_data_byte),
      .req_pkt_kind    (req_pkt_kind),
      .req_pkt_flags   (req_pkt_flags),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_header_word (rsp_header_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_dropped     (rsp_dropped),
      .rsp_last_word   (rsp_last_word),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   class header_predictor;
      typedef struct packed {
         logic [31:0]                    word;
         logic [phf_pkg::WORD_IDX_W-1:0] index;
         logic                           dropped;
         logic                           last;
      } header_result_type;

      logic [31:0]       stream_value;
      logic [31:0]       magic;
      logic [15:0]       version;
      logic [31:0]       crc_acc;
      logic [10:0]       byte_total;
      logic [31:0]       seq_num;
      header_result_type pending_words[$];
      int unsigned       errors;

      function new();
         stream_value = 32'd1;
         magic = 32'd0;
         version = 16'd1;
         crc_acc = phf_pkg::CRC_ONES;
         byte_total = 11'd0;
         seq_num = 32'd0;
         errors = 0;
      endfunction

      function void write_reg(input logic [phf_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [31:0] value);
         case (idx)
            phf_pkg::CSR_STREAM_IDENT: begin
               stream_value = (value == 32'd0) ? 32'd1 : value;
               seq_num = 32'd0;
            end
            phf_pkg::CSR_MAGIC_WORD: magic = value;
            phf_pkg::CSR_FORMAT_VERSION: version = value[15:0];
            default: ;
         endcase
      endfunction

      function void take_item(input logic mode, input logic [7:0] data,
                              input logic [15:0] kind, input logic [15:0] flags);
         logic [31:0]       words [8];
         header_result_type r;
         if (mode == 1'b0) begin
            crc_acc = crc_acc ^ {24'd0, data};
            for (int k = 0; k < 8; k++) begin
               crc_acc = {1'b0, crc_acc[31:1]} ^ (crc_acc[0] ? phf_pkg::CRC_POLY : 32'd0);
            end
            if (byte_total <= phf_pkg::MAX_PAYLOAD_DEF) begin
               byte_total = byte_total + 11'd1;
            end
            return;
         end
         if (byte_total > phf_pkg::MAX_PAYLOAD_DEF) begin
            r.word = 32'd0;
            r.index = phf_pkg::WORD_MAGIC;
            r.dropped = 1'b1;
            r.last = 1'b1;
            pending_words.push_back(r);
         end else begin
            words = '{magic, {phf_pkg::HDR_BYTES, version}, stream_value, seq_num,
                      {flags, kind}, {21'd0, byte_total}, ~crc_acc, 32'd0};
            for (int k = 0; k < 8; k++) begin
               r.word = words[k];
               r.index = phf_pkg::WORD_IDX_W'(k);
               r.dropped = 1'b0;
               r.last = (r.index == phf_pkg::WORD_LAST);
               pending_words.push_back(r);
            end
            seq_num = seq_num + 32'd1;
         end
         crc_acc = phf_pkg::CRC_ONES;
         byte_total = 11'd0;
      endfunction

      function void check_word(input logic [31:0] word,
                               input logic [phf_pkg::WORD_IDX_W-1:0] index,
                               input logic dropped, input logic last);
         header_result_type want;
         if (pending_words.size() == 0) begin
            $error("response transfer with nothing pending: header_word %h", word);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         if (word !== want.word) begin
            $error("header_word: expected %h, actual %h", want.word, word);
            errors++;
         end
         if (index !== want.index) begin
            $error("word_index: expected %0d, actual %0d", want.index, index);
            errors++;
         end
         if (dropped !== want.dropped) begin
            $error("dropped: expected %b, actual %b", want.dropped, dropped);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_word: expected %b, actual %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   header_predictor pred = new();

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pred.take_item(req_mode, req_data_byte, req_pkt_kind, req_pkt_flags);
         end
         if (rsp_valid && !rsp_stall) begin
            pred.check_word(rsp_header_word, rsp_word_index, rsp_dropped, rsp_last_word);
         end
         if (csr_valid && csr_ready) begin
            pred.write_reg(csr_index, csr_data);
         end
      end
   end

   // response side back-pressure
   initial begin
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input logic mode, input logic [7:0] data,
                            input logic [15:0] kind, input logic [15:0] flags);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_data_byte <= data;
      req_pkt_kind <= kind;
      req_pkt_flags <= flags;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_packet(input int unsigned len);
      for (int unsigned n = 0; n < len; n++) begin
         send_item(1'b0, 8'($urandom), 16'($urandom), 16'($urandom));
      end
      send_item(1'b1, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pred.pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [phf_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] stream, input logic [31:0] magic,
                             input logic [31:0] version);
      csr_write(phf_pkg::CSR_STREAM_IDENT, stream);
      csr_write(phf_pkg::CSR_MAGIC_WORD, magic);
      csr_write(phf_pkg::CSR_FORMAT_VERSION, version);
   endtask

   initial begin
      int unsigned random_start;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= 1'b0;
      req_data_byte <= 8'd0;
      req_pkt_kind <= 16'd0;
      req_pkt_flags <= 16'd0;
      csr_valid <= 1'b0;
      csr_index <= phf_pkg::CSR_STREAM_IDENT;
      csr_data <= 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty packet, then byte and field extremes at reset settings
      send_item(1'b1, 8'hff, 16'h0000, 16'h0000);
      send_item(1'b0, 8'h00, 16'hffff, 16'hffff);
      send_item(1'b0, 8'hff, 16'h0000, 16'h0000);
      send_item(1'b1, 8'h00, 16'hffff, 16'hffff);
      drain();

      // stream id zero, unused index ignored
      csr_write(phf_pkg::CSR_STREAM_IDENT, 32'd0);
      csr_write(phf_pkg::CSR_MAGIC_WORD, 32'hffff_ffff);
      csr_write(phf_pkg::CSR_FORMAT_VERSION, 32'hdead_ffff);
      csr_write(CSR_SPARE_INDEX, 32'h1234_5678);
      send_item(1'b0, 8'h31, 16'h0001, 16'h8000);
      send_item(1'b0, 8'h32, 16'h0000, 16'h0000);
      send_item(1'b1, 8'h5a, 16'h8001, 16'h0180);
      send_item(1'b1, 8'ha5, 16'h7ffe, 16'hfe7f);

      // stream id write in the middle of a packet
      send_item(1'b0, 8'h55, 16'h0000, 16'h0000);
      send_item(1'b0, 8'haa, 16'h0000, 16'h0000);
      drain();
      csr_write(phf_pkg::CSR_STREAM_IDENT, 32'hffff_ffff);
      send_item(1'b0, 8'h0f, 16'h0000, 16'h0000);
      send_item(1'b0, 8'hf0, 16'h0000, 16'h0000);
      send_item(1'b1, 8'h00, 16'h1234, 16'habcd);

      random_start = items_sent;
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         case (ph)
            0: set_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
            1: set_config(32'd0, 32'd0, 32'd0);
            default: set_config($urandom, $urandom, $urandom);
         endcase
         while (items_sent < random_start + (ph + 1) * RANDOM_ITEMS / 4) begin
            send_packet(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12));
         end
         if (ph == 1) begin
            // long receiver hold while closes keep coming
            hold_req = 1'b1;
            repeat (6) send_packet(2);
            drain();
         end
      end

      // largest payloads: at the limit, then over it with a saturated count
      send_packet(phf_pkg::MAX_PAYLOAD_DEF);
      send_packet(phf_pkg::MAX_PAYLOAD_DEF + 3);
      send_packet(3);

      calm = 1'b1;
      repeat (6) send_packet($urandom_range(0, 6));

      drain();
      repeat (16) @(posedge clock);
      if (pred.errors == 0 && pred.pending_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
